/* rtl/rcm_pkg.sv */
// ============================================================================
// rcm_pkg: shared types and arithmetic for the RC mode sequencer
// Channel classification and scaling, boom target helper, item and
// configuration structures used across the front, queue and back sections.
// ============================================================================
`default_nettype none

package rcm_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_SLEEP_HOLD_TICKS      = 3'd0,
    CFG_START_POSE_HOLD_TICKS = 3'd1,
    CFG_WAKE_MOVE_LEVEL       = 3'd2,
    CFG_BOOM_UP_MOVE_LEVEL    = 3'd3,
    CFG_ROLL_DEAD_BAND        = 3'd4,
    CFG_ROLL_ATTACK_LEVEL     = 3'd5,
    CFG_ROLL_ADJUST_SPEED     = 3'd6,
    CFG_ROLL_ATTACK_SPEED     = 3'd7
  } cfg_idx_t;

  // Boom positions and gains.
  localparam int BOOM_POS_NORMAL   = 0;
  localparam int BOOM_POS_RAISED   = 2000;
  localparam int BOOM_POS_ROLLING  = 4000;
  localparam int BOOM_GAIN_NORMAL  = 1000;
  localparam int BOOM_GAIN_RAISED  = 1000;
  localparam int BOOM_GAIN_ROLLING = 1000;

  // Scaling: q = (mag * 628 + 12) / 25, done as one multiply by the
  // reciprocal ceil(2^25 / 25) folded with the constant 628.
  localparam logic [40:0] SCALE_MUL   = 41'd842887784;
  localparam logic [40:0] SCALE_ADD   = 41'd16106136;
  localparam logic [10:0] SAT_MAG     = 11'd652;
  localparam logic [14:0] Q_ONE       = 15'd16384;
  localparam logic [12:0] CH_CENTER   = 13'd1024;
  localparam logic [5:0]  MOVE_Y_OFFS = 6'd32;
  localparam logic [5:0]  NO_OFFS     = 6'd0;
  localparam int          QUEUE_DEPTH = 2;

  // Classified raw channel: sign of the final value, saturation flag and
  // the distance from center when not saturated.
  typedef struct packed {
    logic       neg;
    logic       sat;
    logic [9:0] mag;
  } chan_t;

  // Scaled channel as sign and magnitude, magnitude at most Q_ONE.
  typedef struct packed {
    logic        neg;
    logic [14:0] mag;
  } sval_t;

  typedef struct packed {
    logic  failsafe;
    logic  sleep_button;
    chan_t roll;
    chan_t move_x;
    chan_t boom;
    chan_t move_y;
  } item_t;

  typedef struct packed {
    logic        [11:0] sleep_hold;
    logic        [11:0] start_hold;
    logic        [29:0] wake_sq;
    logic        [29:0] boom_up_sq;
    logic        [14:0] roll_dead_band;
    logic        [14:0] roll_attack_level;
    logic        [14:0] roll_adjust_speed;
    logic signed [15:0] roll_attack_speed;
  } cfg_t;

  function automatic chan_t classify(input logic [10:0] raw, input logic [5:0] offs,
                                     input logic invert);
    logic signed [12:0] d;
    logic        [10:0] mag;
    chan_t              c;
    d     = $signed(13'(raw) + 13'(offs) - CH_CENTER);
    mag   = d[12] ? 11'(-d) : 11'(d);
    c.neg = d[12] ^ invert;
    c.sat = (mag > SAT_MAG);
    c.mag = mag[9:0];
    return c;
  endfunction

  function automatic sval_t scale(input chan_t c);
    logic [40:0] prod;
    sval_t       s;
    prod  = 41'(c.mag) * SCALE_MUL + SCALE_ADD;
    s.neg = c.neg;
    s.mag = c.sat ? Q_ONE : prod[39:25];
    return s;
  endfunction

  // trunc(gain * boom / 16384), computed on magnitudes so that the
  // truncation goes toward zero.
  function automatic logic signed [17:0] boom_quot(input int gain, input sval_t b);
    logic        gneg;
    logic [16:0] gabs;
    logic [31:0] p;
    logic [17:0] qm;
    gneg = (gain < 0);
    gabs = gneg ? 17'(-gain) : 17'(gain);
    p    = 32'(gabs) * 32'(b.mag);
    qm   = p[31:14];
    return (gneg ^ b.neg) ? $signed(18'd0 - qm) : $signed(qm);
  endfunction

endpackage

`default_nettype wire

/* rtl/rc_mode_sequencer_and_drive_mixer_top.sv */
// ============================================================================
// rc_mode_sequencer_and_drive_mixer_top: RC mode sequencer and drive mixer
// Scales four radio channels, runs the sleep / starting-pose sequence and
// produces the roll drive, boom mode, boom target and movement power.
// ============================================================================
// Each tick is held in the queue, then in the back sequencer, then in the result register.
// The back sequencer works on one tick at a time: it runs two shared channel scalers
// and one squaring multiplier over four steps, the last waiting for a free result slot.
// Ticks with control disabled are dropped at the input and give no result.
// Reset (synchronous, active high) restores register defaults, sets the mode
// to normal, clears the hold counter and empties the queue and result stage.
`default_nettype none

module rc_mode_sequencer_and_drive_mixer_top (
  input  wire logic               clk,
  input  wire logic               rst,
  // Configuration write port
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_wdata,
  // Tick input channel
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               control_enabled,
  input  wire logic               failsafe,
  input  wire logic               sleep_button,
  input  wire logic [10:0]        ch_roll,
  input  wire logic [10:0]        ch_move_x,
  input  wire logic [10:0]        ch_boom,
  input  wire logic [10:0]        ch_move_y,
  // Result channel
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic        [1:0]       robot_mode,
  output logic                    drive_enabled,
  output logic signed [15:0]      roll_drive,
  output logic        [1:0]       boom_mode,
  output logic signed [17:0]      boom_target,
  output logic        [29:0]      move_power
);

  // Register defaults. The two movement levels are only ever compared
  // against the squared movement power, so they are held as squares.
  localparam logic [11:0] SLEEP_HOLD_RST    = 12'd200;
  localparam logic [11:0] START_HOLD_RST    = 12'd50;
  localparam logic [29:0] WAKE_SQ_RST       = 30'd16777216;
  localparam logic [29:0] BOOM_UP_SQ_RST    = 30'd67108864;
  localparam logic [14:0] DEADZONE_RST      = 15'd1638;
  localparam logic [14:0] ATTACK_LEVEL_RST  = 15'd13107;
  localparam logic [14:0] ADJUST_SPEED_RST  = 15'd4096;
  localparam logic [15:0] ATTACK_SPEED_RST  = 16'd16384;

  rcm_pkg::cfg_t cfg;

  // The square of a written level is formed on the way into the register,
  // so the sequencer needs no extra multiply per tick for the thresholds.
  logic [29:0] wdata_sq;
  assign wdata_sq = 30'(cfg_wdata[14:0]) * 30'(cfg_wdata[14:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sleep_hold        <= SLEEP_HOLD_RST;
      cfg.start_hold        <= START_HOLD_RST;
      cfg.wake_sq           <= WAKE_SQ_RST;
      cfg.boom_up_sq        <= BOOM_UP_SQ_RST;
      cfg.roll_dead_band    <= DEADZONE_RST;
      cfg.roll_attack_level <= ATTACK_LEVEL_RST;
      cfg.roll_adjust_speed <= ADJUST_SPEED_RST;
      cfg.roll_attack_speed <= $signed(ATTACK_SPEED_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        rcm_pkg::CFG_SLEEP_HOLD_TICKS:      cfg.sleep_hold        <= cfg_wdata[11:0];
        rcm_pkg::CFG_START_POSE_HOLD_TICKS: cfg.start_hold        <= cfg_wdata[11:0];
        rcm_pkg::CFG_WAKE_MOVE_LEVEL:       cfg.wake_sq           <= wdata_sq;
        rcm_pkg::CFG_BOOM_UP_MOVE_LEVEL:    cfg.boom_up_sq        <= wdata_sq;
        rcm_pkg::CFG_ROLL_DEAD_BAND:        cfg.roll_dead_band    <= cfg_wdata[14:0];
        rcm_pkg::CFG_ROLL_ATTACK_LEVEL:     cfg.roll_attack_level <= cfg_wdata[14:0];
        rcm_pkg::CFG_ROLL_ADJUST_SPEED:     cfg.roll_adjust_speed <= cfg_wdata[14:0];
        rcm_pkg::CFG_ROLL_ATTACK_SPEED:     cfg.roll_attack_speed <= $signed(cfg_wdata);
        default: begin
        end
      endcase
    end
  end

  // Front: a transfer happens whenever the queue has room; disabled ticks
  // are transferred and discarded without taking a queue entry.
  logic            push;
  rcm_pkg::item_t  push_item;
  logic            q_full;
  logic            q_not_empty;
  logic            q_pop;
  rcm_pkg::item_t  q_head;

  rcm_front u_front (
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .control_enabled (control_enabled),
    .failsafe        (failsafe),
    .sleep_button    (sleep_button),
    .ch_roll         (ch_roll),
    .ch_move_x       (ch_move_x),
    .ch_boom         (ch_boom),
    .ch_move_y       (ch_move_y),
    .q_full          (q_full),
    .push            (push),
    .push_item       (push_item)
  );

  // The queue decouples the front from the back, so a stalled result
  // does not stop new ticks from being transferred until it fills.
  rcm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  // Back: scales, squares, updates the mode state and owns the result
  // register, which holds a finished result until the sink takes it.
  rcm_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_valid       (q_not_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .robot_mode    (robot_mode),
    .drive_enabled (drive_enabled),
    .roll_drive    (roll_drive),
    .boom_mode     (boom_mode),
    .boom_target   (boom_target),
    .move_power    (move_power)
  );

endmodule

`default_nettype wire

/* rtl/rcm_front.sv */
// ============================================================================
// rcm_front: input acceptance and channel classification
// Drops ticks with control disabled and turns raw channels into sign,
// saturation and magnitude before they enter the queue.
// ============================================================================
`default_nettype none

module rcm_front (
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          control_enabled,
  input  wire logic          failsafe,
  input  wire logic          sleep_button,
  input  wire logic [10:0]   ch_roll,
  input  wire logic [10:0]   ch_move_x,
  input  wire logic [10:0]   ch_boom,
  input  wire logic [10:0]   ch_move_y,
  input  wire logic          q_full,
  output logic               push,
  output rcm_pkg::item_t     push_item
);

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full && control_enabled;

  always_comb begin
    push_item.failsafe     = failsafe;
    push_item.sleep_button = sleep_button;
    push_item.roll   = rcm_pkg::classify(ch_roll, rcm_pkg::NO_OFFS, 1'b0);
    // The movement X channel's sign is inverted at classification, before scaling.
    push_item.move_x = rcm_pkg::classify(ch_move_x, rcm_pkg::NO_OFFS, 1'b1);
    push_item.boom   = rcm_pkg::classify(ch_boom, rcm_pkg::NO_OFFS, 1'b0);
    push_item.move_y = rcm_pkg::classify(ch_move_y, rcm_pkg::MOVE_Y_OFFS, 1'b0);
  end

endmodule

`default_nettype wire

/* rtl/rcm_queue.sv */
// ============================================================================
// rcm_queue: two-entry queue between front and back
// Lets the front keep accepting while the back sequencer works on an item.
// ============================================================================
`default_nettype none

module rcm_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire rcm_pkg::item_t  push_item,
  input  wire logic            pop,
  output rcm_pkg::item_t       head,
  output logic                 not_empty,
  output logic                 full
);

  rcm_pkg::item_t entries [rcm_pkg::QUEUE_DEPTH];
  logic [0:0] wr_ptr;
  logic [0:0] rd_ptr;
  logic [1:0] count;

  assign head      = entries[rd_ptr];
  assign not_empty = (count != 2'd0);
  assign full      = (count == 2'(rcm_pkg::QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> not_empty)
    else $error("queue pop while empty");

endmodule

`default_nettype wire

/* rtl/rcm_back.sv */
// ============================================================================
// rcm_back: scaling, mode sequencing and drive mixing
// A four-step sequencer shares two channel scalers and one squaring
// multiplier, updates the mode state and loads the result register.
// ============================================================================
`default_nettype none

module rcm_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire rcm_pkg::cfg_t       cfg,
  input  wire logic                q_valid,
  input  wire rcm_pkg::item_t      q_head,
  output logic                     q_pop,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic        [1:0]        robot_mode,
  output logic                     drive_enabled,
  output logic signed [15:0]       roll_drive,
  output logic        [1:0]        boom_mode,
  output logic signed [17:0]       boom_target,
  output logic        [29:0]       move_power
);

  typedef enum logic [1:0] {
    S_IDLE, S_SQ_X, S_SQ_Y, S_OUT
  } state_t;

  typedef enum logic [1:0] {
    MODE_NORMAL, MODE_POSE_READY, MODE_STARTING_POSE, MODE_SLEEPING
  } mode_t;

  typedef enum logic [1:0] {
    BOOM_MODE_NORMAL, BOOM_MODE_RAISED, BOOM_MODE_ROLLING
  } bmode_t;

  state_t state;
  mode_t  mode_q;
  logic [12:0] hold_count;

  logic            fs;
  logic            btn;
  rcm_pkg::chan_t  roll_c;
  rcm_pkg::chan_t  boom_c;
  rcm_pkg::sval_t  mx_s;
  rcm_pkg::sval_t  my_s;
  rcm_pkg::sval_t  roll_s;
  rcm_pkg::sval_t  boom_s;
  logic [29:0]     pw;
  logic signed [17:0] quot_normal;
  logic signed [17:0] quot_raised;
  logic signed [17:0] quot_rolling;

  // Shared scalers and squarer.
  rcm_pkg::chan_t  sc_a_in;
  rcm_pkg::chan_t  sc_b_in;
  rcm_pkg::sval_t  sc_a;
  rcm_pkg::sval_t  sc_b;
  logic [14:0]     sq_in;
  logic [29:0]     sq;

  always_comb begin
    sc_a_in = (state == S_IDLE) ? q_head.move_x : roll_c;
    sc_b_in = (state == S_IDLE) ? q_head.move_y : boom_c;
    sc_a    = rcm_pkg::scale(sc_a_in);
    sc_b    = rcm_pkg::scale(sc_b_in);
    sq_in   = (state == S_SQ_X) ? mx_s.mag : my_s.mag;
    sq      = 30'(sq_in) * 30'(sq_in);
  end

  assign q_pop = (state == S_IDLE) && q_valid;

  // Decision logic for the final step.
  logic [12:0]        hold_next;
  mode_t              mode_next;
  logic               roll_isneg;
  logic               attack;
  logic signed [15:0] roll_val;
  bmode_t             bmode;
  logic signed [17:0] quot_sel;
  logic signed [18:0] target_sum;
  logic               slot_free;

  assign slot_free = !out_valid || out_ready;

  always_comb begin
    if (btn) begin
      hold_next = (hold_count <= {1'b0, cfg.sleep_hold}) ? hold_count + 13'd1 : hold_count;
    end else begin
      hold_next = '0;
    end

    mode_next = mode_q;
    if (fs) begin
      mode_next = MODE_SLEEPING;
    end else begin
      if (hold_next == 13'd0 && mode_q == MODE_POSE_READY) begin
        mode_next = MODE_STARTING_POSE;
      end else if (hold_next >= {1'b0, cfg.sleep_hold}) begin
        mode_next = MODE_SLEEPING;
      end else if (hold_next >= {1'b0, cfg.start_hold}) begin
        mode_next = MODE_POSE_READY;
      end
      if (pw > cfg.wake_sq) mode_next = MODE_NORMAL;
    end

    roll_isneg = roll_s.neg && (roll_s.mag != 15'd0);
    attack     = 1'b0;
    if (roll_s.mag < cfg.roll_dead_band) begin
      roll_val = '0;
    end else if (mode_next != MODE_STARTING_POSE && !roll_isneg &&
                 roll_s.mag > cfg.roll_attack_level) begin
      roll_val = cfg.roll_attack_speed;
      attack   = 1'b1;
    end else if (roll_isneg) begin
      roll_val = $signed(16'd0 - {1'b0, cfg.roll_adjust_speed});
    end else begin
      roll_val = $signed({1'b0, cfg.roll_adjust_speed});
    end

    if (attack) begin
      bmode = BOOM_MODE_ROLLING;
    end else if (pw > cfg.boom_up_sq) begin
      bmode = BOOM_MODE_RAISED;
    end else begin
      bmode = BOOM_MODE_NORMAL;
    end

    case (bmode)
      BOOM_MODE_NORMAL: begin
        quot_sel   = quot_normal;
        target_sum = $signed(19'(rcm_pkg::BOOM_POS_NORMAL)) + 19'(quot_sel);
      end
      BOOM_MODE_RAISED: begin
        quot_sel   = quot_raised;
        target_sum = $signed(19'(rcm_pkg::BOOM_POS_RAISED)) + 19'(quot_sel);
      end
      BOOM_MODE_ROLLING: begin
        quot_sel   = quot_rolling;
        target_sum = $signed(19'(rcm_pkg::BOOM_POS_ROLLING)) + 19'(quot_sel);
      end
      default: begin
        quot_sel   = '0;
        target_sum = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      mode_q     <= MODE_NORMAL;
      hold_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      // The result register fills at the final step and empties on a transfer.
      if (state == S_OUT && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            fs     <= q_head.failsafe;
            btn    <= q_head.sleep_button;
            roll_c <= q_head.roll;
            boom_c <= q_head.boom;
            mx_s   <= sc_a;
            my_s   <= sc_b;
            state  <= S_SQ_X;
          end
        end
        S_SQ_X: begin
          pw     <= sq;
          roll_s <= sc_a;
          boom_s <= sc_b;
          state  <= S_SQ_Y;
        end
        S_SQ_Y: begin
          pw           <= pw + sq;
          quot_normal  <= rcm_pkg::boom_quot(rcm_pkg::BOOM_GAIN_NORMAL, boom_s);
          quot_raised  <= rcm_pkg::boom_quot(rcm_pkg::BOOM_GAIN_RAISED, boom_s);
          quot_rolling <= rcm_pkg::boom_quot(rcm_pkg::BOOM_GAIN_ROLLING, boom_s);
          state        <= S_OUT;
        end
        S_OUT: begin
          if (slot_free) begin
            hold_count <= hold_next;
            mode_q     <= mode_next;
            robot_mode <= mode_next;
            move_power <= pw;
            if (mode_next == MODE_SLEEPING) begin
              drive_enabled <= 1'b0;
              roll_drive    <= '0;
              boom_mode     <= '0;
              boom_target   <= '0;
            end else begin
              drive_enabled <= 1'b1;
              roll_drive    <= roll_val;
              boom_mode     <= bmode;
              boom_target   <= $signed(target_sum[17:0]);
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_hold_bound: assert property (@(posedge clk) disable iff (rst)
    hold_count <= 13'd4096)
    else $error("hold counter beyond its saturation point");
  a_sleep_drive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (drive_enabled == (robot_mode != MODE_SLEEPING)))
    else $error("drive enable disagrees with the reported mode");
  a_result_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && slot_free) |=> (out_valid && state == S_IDLE))
    else $error("final step did not load the result register");
  a_sleep_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !drive_enabled) |-> (roll_drive == 16'sd0 && boom_target == 18'sd0))
    else $error("drives not zero while sleeping");

endmodule

`default_nettype wire
